// ===== src/integer_to_ascii_formatter_defines.svh =====
// Assertion macros for the integer-to-ASCII formatter checker.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication
`define ITOA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/itoa_pkg.sv =====
package itoa_pkg;

  // Format codes
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEXL = 3'd2;
  localparam logic [2:0] OP_HEXU = 3'd3;
  localparam logic [2:0] OP_PTR  = 3'd4;

  localparam logic [30:0] CNT_MAX   = 31'h7FFF_FFFF;
  // ceil(2^35 / 10): floor(x * DEC_RECIP / 2^35) == x / 10 for every 32-bit x
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam logic [7:0]  CH_ZERO   = 8'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREFIX,
    ST_DIGITS
  } state_t;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX,
    PFX_NIL
  } prefix_t;

  typedef struct packed {
    logic        start;
    logic        hex;
    logic [63:0] value;
    logic [3:0]  rd_idx;
  } conv_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [4:0] count;
    logic [3:0] digit;
  } conv_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      base = CH_ZERO;
    end else if (upper) begin
      base = 8'd55;
    end else begin
      base = 8'd87;
    end
    return base + {4'b0, d};
  endfunction

  function automatic logic [2:0] prefix_len(input prefix_t kind);
    logic [2:0] len;
    case (kind)
      PFX_MINUS: len = 3'd1;
      PFX_HEX:   len = 3'd2;
      PFX_NIL:   len = 3'd5;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] prefix_char(input prefix_t kind, input logic [2:0] idx);
    logic [7:0] ch;
    case (kind)
      PFX_MINUS: ch = "-";
      PFX_HEX:   ch = (idx == 3'd0) ? "0" : "x";
      PFX_NIL: begin
        case (idx)
          3'd0:    ch = "(";
          3'd1:    ch = "n";
          3'd2:    ch = "i";
          3'd3:    ch = "l";
          default: ch = ")";
        endcase
      end
      default:   ch = CH_ZERO;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/integer_to_ascii_formatter.sv =====
// Integer-to-ASCII formatter. Each input beat carries a format code and a 64-bit value; the
// block answers with the value's text, one ASCII character per output beat, most significant
// digit first, with last set on the final character. Formats: signed 32-bit decimal (leading
// '-', the most negative value included), unsigned 32-bit decimal, 64-bit hex in lower or
// upper case without leading zeros, and pointer ("(nil)" for zero, else "0x" and lower-case
// hex). Codes 5 to 7 are taken and dropped with no output. printed_total counts characters
// since reset, this one included, and saturates at 2^31-1. One item at a time: in_stall is high
// from the cycle after an accept of codes 0 to 4 until the last character is loaded into the
// output register. The digits come out of one shared divide-by-ten (reciprocal multiplier)
// or nibble-shift unit at one digit per cycle, then characters leave at one per cycle,
// while out_stall is low, through the output register.
module integer_to_ascii_formatter
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  character,
  output logic        last,
  output logic [30:0] printed_total
);

  state_t      state;
  state_t      state_next;
  prefix_t     kind;
  prefix_t     kind_in;
  logic        upper;
  logic [2:0]  pidx;
  logic [4:0]  didx;
  logic [4:0]  didx_next;
  logic [4:0]  didx_m1;
  logic [4:0]  rd_addr;
  logic [2:0]  plen;

  conv_ctrl_t  cctrl;
  conv_stat_t  cstat;

  logic        accept;
  logic        load;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;
  logic        op_bad;
  logic        is_nil;
  logic        neg;
  logic [31:0] lo;

  itoa_conv u_conv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cctrl),
    .stat (cstat)
  );

  // Decode the incoming beat
  always_comb begin
    lo     = value[31:0];
    op_bad = operation > OP_PTR;
    is_nil = (operation == OP_PTR) && (value == 64'd0);
    neg    = (operation == OP_SDEC) && lo[31];
    if (neg) begin
      kind_in = PFX_MINUS;
    end else if (is_nil) begin
      kind_in = PFX_NIL;
    end else if (operation == OP_PTR) begin
      kind_in = PFX_HEX;
    end else begin
      kind_in = PFX_NONE;
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  // Output register is free when empty or being drained this cycle
  assign load     = ~out_valid || ~out_stall;
  assign plen     = prefix_len(kind);
  assign didx_m1  = didx - 5'd1;
  // The digit store has a registered read, so address it with the next digit index
  assign rd_addr  = didx_next - 5'd1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !op_bad) begin
          state_next = is_nil ? ST_PREFIX : ST_CONV;
        end
      end
      ST_CONV: begin
        if (cstat.done) begin
          state_next = (kind == PFX_NONE) ? ST_DIGITS : ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        if (load && (pidx == plen - 3'd1)) begin
          state_next = (kind == PFX_NIL) ? ST_IDLE : ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (load && (didx == 5'd1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Digit index: load the digit count when conversion ends, count down per digit
  always_comb begin
    didx_next = didx;
    if (state == ST_CONV && cstat.done) begin
      didx_next = cstat.count;
    end else if (state == ST_DIGITS && load) begin
      didx_next = didx_m1;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    cctrl.start  = accept && !op_bad && !is_nil;
    cctrl.hex    = operation >= OP_HEXL;
    cctrl.value  = (operation >= OP_HEXL) ? value
                 : {32'b0, (neg ? (~lo + 32'd1) : lo)};
    cctrl.rd_idx = rd_addr[3:0];
    emit         = 1'b0;
    emit_char    = CH_ZERO;
    emit_last    = 1'b0;
    case (state)
      ST_PREFIX: begin
        emit      = load;
        emit_char = prefix_char(kind, pidx);
        emit_last = (kind == PFX_NIL) && (pidx == plen - 3'd1);
      end
      ST_DIGITS: begin
        emit      = load;
        emit_char = digit_char(cstat.digit, upper);
        emit_last = (didx == 5'd1);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      printed_total <= 31'd0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= emit;
      end
      // Advance the saturating count with every character loaded
      if (emit && (printed_total != CNT_MAX)) begin
        printed_total <= printed_total + 31'd1;
      end
    end
  end

  // Payload and per-item bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= kind_in;
      upper <= (operation == OP_HEXU);
      pidx  <= 3'd0;
    end else if (state == ST_PREFIX && load) begin
      pidx <= pidx + 3'd1;
    end
    didx <= didx_next;
    if (emit) begin
      character <= emit_char;
      last      <= emit_last;
    end
  end

endmodule

// ===== src/itoa_conv.sv =====
// Digit extractor: one digit per cycle, least significant first, into a small digit store.
module itoa_conv
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  conv_ctrl_t ctrl,
  output conv_stat_t stat
);

  logic [63:0] cur;
  logic        hex;
  logic        run;
  logic [4:0]  cnt;
  logic [3:0]  digs [16];
  logic [3:0]  rd_digit;

  logic [63:0] prod;
  logic [28:0] quot;
  logic [31:0] quot10;
  logic [31:0] rem;
  logic [3:0]  digit;
  logic [63:0] cur_next;
  logic        finish;

  // Shared step: divide by ten through the reciprocal, or shift one nibble
  always_comb begin
    prod     = {32'b0, cur[31:0]} * {32'b0, DEC_RECIP};
    quot     = prod[63:35];
    quot10   = {quot, 3'b0} + {2'b0, quot, 1'b0};
    rem      = cur[31:0] - quot10;
    digit    = hex ? cur[3:0] : rem[3:0];
    cur_next = hex ? {4'b0, cur[63:4]} : {35'b0, quot};
    finish   = (cur_next == 64'd0) || (cnt == 5'd15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= 5'd0;
    end else if (ctrl.start) begin
      run <= 1'b1;
      cnt <= 5'd0;
    end else if (run) begin
      cnt <= cnt + 5'd1;
      if (finish) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cur <= ctrl.value;
      hex <= ctrl.hex;
    end else if (run) begin
      cur <= cur_next;
      digs[cnt[3:0]] <= digit;
    end
  end

  // Registered read; the caller presents the address in the cycle before the digit is used
  always_ff @(posedge clk) begin
    rd_digit <= digs[ctrl.rd_idx];
  end

  assign stat.done  = ~run;
  assign stat.count = cnt;
  assign stat.digit = rd_digit;

endmodule

// ===== src/itoa_checker.sv =====
`include "integer_to_ascii_formatter_defines.svh"

module itoa_checker
  import itoa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  operation,
  input logic [63:0] value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  character,
  input logic        last,
  input logic [30:0] printed_total
);

  // Hold a stalled output beat
  `ITOA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(character) && $stable(last) && $stable(printed_total), "stalled output beat changed")

  // Each new beat carries the count one past the previous beat, saturating
  `ITOA_ASSERT_NEXT(a_total_step, out_valid && !out_stall, !out_valid || (printed_total == (($past(printed_total) == CNT_MAX) ? CNT_MAX : $past(printed_total) + 31'd1)), "printed_total did not advance by one")

  // Input stays stalled while a text is only partly out
  `ITOA_ASSERT_SAME(a_busy_mid_text, out_valid && !last, in_stall, "input taken in the middle of a text")

  // Drop an unused format code without going busy
  `ITOA_ASSERT_NEXT(a_drop_bad_op, in_valid && !in_stall && (operation > OP_PTR), !in_stall, "unused format code made the block busy")

  // Hold a stalled input beat
  `ITOA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(operation) && $stable(value), "stalled input beat changed")

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);

// ===== test/testbench.sv =====
module testbench;
  import itoa_pkg::*;

  // Run length and pacing
  localparam int RANDOM_ITEMS   = 360;
  localparam int NUM_CODES      = 8;     // every code the 3-bit operation field can carry
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 60;    // leave room for stalls
  localparam int HOLD_CYCLES    = 300;   // one long receiver hold-off
  localparam int HOLD_AFTER     = 150;   // characters checked before the hold-off starts
  localparam int STALL_PHASE    = 400;   // cycles per receiver stall pattern

  // Scoreboard: predicts the text for every accepted beat and checks each character beat
  // against the oldest prediction, in order.
  class text_scoreboard;
    typedef struct packed {
      logic [7:0]  ch;
      logic        is_last;
      logic [30:0] total;
    } char_beat_t;

    char_beat_t  expected_chars[$];
    logic [7:0]  text_buf[$];
    logic [30:0] char_count;
    int          errors;
    int          chars_checked;

    function new();
      char_count    = '0;
      errors        = 0;
      chars_checked = 0;
    endfunction

    // Append the decimal digits of mag, most significant first.
    function void append_decimal(logic [31:0] mag);
      logic [7:0]  digits[$];
      logic [31:0] rest;
      rest = mag;
      do begin
        digits.push_front(CH_ZERO + 8'(rest % 32'd10));
        rest = rest / 32'd10;
      end while (rest != 32'd0);
      foreach (digits[i]) text_buf.push_back(digits[i]);
    endfunction

    // Append the hex digits of v with no leading zeros.
    function void append_hex(logic [63:0] v, logic upper);
      logic [7:0]  digits[$];
      logic [63:0] rest;
      logic [3:0]  nib;
      rest = v;
      do begin
        nib = rest[3:0];
        if (nib < 4'd10) begin
          digits.push_front(CH_ZERO + 8'(nib));
        end else if (upper) begin
          digits.push_front("A" + 8'(nib - 4'd10));
        end else begin
          digits.push_front("a" + 8'(nib - 4'd10));
        end
        rest = rest >> 4;
      end while (rest != 64'd0);
      foreach (digits[i]) text_buf.push_back(digits[i]);
    endfunction

    // Note an accepted input beat: build its text and queue one expected beat per character.
    function void note_item(logic [2:0] op, logic [63:0] val);
      logic [31:0] low_word;
      char_beat_t  beat;
      text_buf.delete();
      low_word = val[31:0];
      case (op)
        OP_SDEC: begin
          if (low_word[31]) begin
            text_buf.push_back("-");
            append_decimal(~low_word + 32'd1);
          end else begin
            append_decimal(low_word);
          end
        end
        OP_UDEC: append_decimal(low_word);
        OP_HEXL: append_hex(val, 1'b0);
        OP_HEXU: append_hex(val, 1'b1);
        OP_PTR: begin
          if (val == 64'd0) begin
            text_buf.push_back("(");
            text_buf.push_back("n");
            text_buf.push_back("i");
            text_buf.push_back("l");
            text_buf.push_back(")");
          end else begin
            text_buf.push_back("0");
            text_buf.push_back("x");
            append_hex(val, 1'b0);
          end
        end
        default: ;  // unused codes: drop, no text
      endcase
      foreach (text_buf[i]) begin
        if (char_count != CNT_MAX) char_count++;
        beat.ch      = text_buf[i];
        beat.is_last = (i == text_buf.size() - 1);
        beat.total   = char_count;
        expected_chars.push_back(beat);
      end
    endfunction

    function void mismatch(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    // Check one accepted output beat against the oldest expected character.
    function void check_char(logic [7:0] ch, logic is_last, logic [30:0] total);
      char_beat_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual 0x%0h", $time, ch);
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (ch !== want.ch)         mismatch("character", want.ch, ch);
      if (is_last !== want.is_last) mismatch("last", want.is_last, is_last);
      if (total !== want.total)   mismatch("printed_total", want.total, total);
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  // Clock, reset and block inputs; every input starts at a known value.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [2:0]  operation = OP_SDEC;
  logic [63:0] value     = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  character;
  logic        last;
  logic [30:0] printed_total;

  text_scoreboard sb = new();
  int             real_sent;

  always #5 clk = ~clk;

  integer_to_ascii_formatter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .character    (character),
    .last         (last),
    .printed_total(printed_total)
  );

  // Monitor: sample both handshakes at the edge. Inputs are driven with nonblocking
  // assignments, so every value read here is the one that held just before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(operation, value);
      if (out_valid && !out_stall) sb.check_char(character, last, printed_total);
    end
  end

  // Offer one input beat and hold it until the block takes it. Leave in_valid high on
  // return so back-to-back beats follow without a gap.
  task automatic send_value(logic [2:0] op, logic [63:0] val);
    in_valid  <= 1'b1;
    operation <= op;
    value     <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Random value with a random magnitude, so short and long texts both show up.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          bits;
    v    = {$urandom, $urandom};
    bits = $urandom_range(0, 64);
    if (bits == 0) begin
      v = '0;
    end else if (bits < 64) begin
      v = v & ((64'd1 << bits) - 64'd1);
    end
    // Now and then set the sign bit of the low word to drive negative decimals.
    if ($urandom_range(0, 3) == 0) v[31] = 1'b1;
    return v;
  endfunction

  // Receiver: stall on a pattern chosen from the cycle count and STALL_PHASE, and hold off
  // once for a long stretch while the sender keeps offering beats, so the block fills
  // up and stalls its input.
  initial begin : receiver
    int  cyc;
    bit  hold_done;
    int  phase;
    cyc       = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!hold_done && sb.chars_checked >= HOLD_AFTER) begin
        hold_done = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end
      phase = (cyc / STALL_PHASE) % 4;
      case (phase)
        0:       out_stall <= 1'b0;                            // no stalls at all
        1:       out_stall <= ($urandom_range(0, 3) == 0);     // light random stalls
        2:       out_stall <= ($urandom_range(0, 3) != 0);     // heavy random stalls
        default: out_stall <= (cyc % 3 == 0);                  // stall when cyc % 3 == 0
      endcase
    end
  end

  // Stimulus: directed corner cases, then random bursts, then drain and report.
  initial begin : stimulus
    int          burst;
    int          gap;
    logic [2:0]  op;
    logic [63:0] val;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Signed decimal: zero, small, extremes, most negative, upper word ignored.
    send_value(OP_SDEC, 64'd0);
    send_value(OP_SDEC, 64'd7);
    send_value(OP_SDEC, 64'h0000_0000_7FFF_FFFF);
    send_value(OP_SDEC, 64'h0000_0000_8000_0000);
    send_value(OP_SDEC, 64'h0000_0000_FFFF_FFFF);
    send_value(OP_SDEC, 64'hFFFF_FFFF_0000_0005);
    // Unsigned decimal: zero, largest, upper word ignored.
    send_value(OP_UDEC, 64'd0);
    send_value(OP_UDEC, 64'h0000_0000_FFFF_FFFF);
    send_value(OP_UDEC, 64'hDEAD_BEEF_0000_0400);
    // Hex: zero, all ones, every digit in both cases.
    send_value(OP_HEXL, 64'd0);
    send_value(OP_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(OP_HEXL, 64'hFEDC_BA98_7654_3210);
    send_value(OP_HEXU, 64'd0);
    send_value(OP_HEXU, 64'h0123_4567_89AB_CDEF);
    send_value(OP_HEXU, 64'h8000_0000_0000_0000);
    // Pointer: nil, smallest, widest.
    send_value(OP_PTR, 64'd0);
    send_value(OP_PTR, 64'd1);
    send_value(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(OP_PTR, 64'hA5A5_0000_0000_00C3);
    // Unused codes: drop silently, with a live value between them.
    for (int c = int'(OP_PTR) + 1; c < NUM_CODES; c++) begin
      send_value(3'(c), 64'hFFFF_FFFF_FFFF_FFFF);
      send_value(OP_UDEC, 64'd10);
    end

    // Random bursts with random gaps; unused codes show up now and then but do not count.
    real_sent = 0;
    while (real_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 19) == 0) begin
          op = 3'($urandom_range(int'(OP_PTR) + 1, NUM_CODES - 1));
        end else begin
          op = 3'($urandom_range(int'(OP_SDEC), int'(OP_PTR)));
          real_sent++;
        end
        val = random_value();
        send_value(op, val);
      end
      // Keep some bursts glued together, space the rest.
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected character, then watch for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a time limit several times the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== integer_to_ascii_formatter.f =====
+incdir+src
src/itoa_pkg.sv
src/itoa_conv.sv
src/integer_to_ascii_formatter.sv
src/itoa_checker.sv
test/testbench.sv
